>>> design/pcb_pkg.sv
// pcb_pkg: shared types, constants and helper functions for the pixel color balance unit
// no dependencies; every design file of the block refers to it by scoped names
package pcb_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam int COORD_BITS   = 12;
	localparam int END_BITS     = COORD_BITS + 1;
	localparam int CMAX         = (1 << CHANNEL_BITS) - 1;

	localparam int GAIN_BITS  = 16;
	localparam int COEF_BITS  = 3 * GAIN_BITS;
	localparam int GAIN_ONE   = 16384;
	localparam int NUM_LANES  = 3;
	localparam int NUM_ZONES  = 3;

	// lightness masks, unsigned Q16
	localparam int MASK_ONE  = 65536;
	localparam int MASK_BITS = 17;
	localparam int L4_BITS   = 19;
	localparam int DIFF_BITS = 21;
	localparam int K_SH      = 120062;
	localparam int K_M1      = 54526;
	localparam int K_M2      = 207618;
	localparam int K_HI      = 142082;

	// 4L = floor((max+min) * 2^17 / CMAX) as a multiply by a rounded-up reciprocal
	localparam int SUM_BITS    = CHANNEL_BITS + 1;
	localparam int L4_SH       = 2 * CHANNEL_BITS + 2;
	localparam longint L4_RECIP = ((longint'(1) << (17 + L4_SH)) + CMAX - 1) / CMAX;
	localparam int RECIP_BITS  = 17 + L4_SH - CHANNEL_BITS + 1;
	localparam int L4_PROD_BITS = SUM_BITS + RECIP_BITS;

	// lane arithmetic
	localparam int SCALE_Q16  = 45875;
	localparam int SCALE_BITS = 17;
	localparam int PROD_BITS  = 32;
	localparam int ACC_BITS   = 33;
	localparam int D_BITS     = 33;
	localparam int EF_BITS    = D_BITS + CHANNEL_BITS + 1;
	localparam int E_BITS     = EF_BITS - 30;
	localparam int V_BITS     = E_BITS + 1;

	localparam int PIPE_DEPTH = 9;

	typedef enum logic [2:0] {
		REG_RED_COEFS   = 3'd0,
		REG_GREEN_COEFS = 3'd1,
		REG_BLUE_COEFS  = 3'd2,
		REG_ZONE_MIN_X  = 3'd3,
		REG_ZONE_MIN_Y  = 3'd4,
		REG_ZONE_END_X  = 3'd5,
		REG_ZONE_END_Y  = 3'd6
	} reg_idx_t;

	typedef logic [2:0] reg_addr_t;

	typedef struct packed {
		logic [COORD_BITS-1:0]   pix_x;
		logic [COORD_BITS-1:0]   pix_y;
		logic [CHANNEL_BITS-1:0] red_in;
		logic [CHANNEL_BITS-1:0] green_in;
		logic [CHANNEL_BITS-1:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] red_out;
		logic [CHANNEL_BITS-1:0] green_out;
		logic [CHANNEL_BITS-1:0] blue_out;
		logic                    was_adjusted;
	} pix_out_t;

	// index 0 shadows, 1 midtones, 2 highlights
	typedef logic [NUM_ZONES-1:0][GAIN_BITS-1:0] gain_set_t;
	typedef logic [NUM_ZONES-1:0][MASK_BITS-1:0] masks_t;

	typedef struct packed {
		gain_set_t [NUM_LANES-1:0] gains;
		logic [COORD_BITS-1:0]     zmin_x;
		logic [COORD_BITS-1:0]     zmin_y;
		logic [END_BITS-1:0]       zend_x;
		logic [END_BITS-1:0]       zend_y;
	} cfg_t;

	// two's complement Q1.14 saturated to +-1.0
	function automatic logic [GAIN_BITS-1:0] sat_gain(input logic [GAIN_BITS-1:0] raw);
		logic signed [GAIN_BITS-1:0] g;
		g = $signed(raw);
		if (g > $signed(GAIN_BITS'(GAIN_ONE)))
			return GAIN_BITS'(GAIN_ONE);
		else if (g < -$signed(GAIN_BITS'(GAIN_ONE)))
			return GAIN_BITS'(-GAIN_ONE);
		else
			return raw;
	endfunction

	function automatic logic [MASK_BITS-1:0] clamp_mask(input logic signed [DIFF_BITS-1:0] v);
		if (v < 0)
			return '0;
		else if (v > $signed(DIFF_BITS'(MASK_ONE)))
			return MASK_BITS'(MASK_ONE);
		else
			return v[MASK_BITS-1:0];
	endfunction

endpackage

>>> design/pcb_cfg.sv
// pcb_cfg: configuration register file of the color balance unit
// gains are saturated to +-1.0 as they are written; uses pcb_pkg
module pcb_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  pcb_pkg::reg_addr_t           wr_index,
	input  logic [pcb_pkg::COEF_BITS-1:0] wr_data,
	output pcb_pkg::cfg_t                cfg
);

	pcb_pkg::cfg_t     cfg_q;
	pcb_pkg::gain_set_t sat_set;

	always_comb begin
		for (int z = 0; z < pcb_pkg::NUM_ZONES; z++) begin
			sat_set[z] = pcb_pkg::sat_gain(wr_data[z*pcb_pkg::GAIN_BITS +: pcb_pkg::GAIN_BITS]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gains  <= '0;
			cfg_q.zmin_x <= '0;
			cfg_q.zmin_y <= '0;
			cfg_q.zend_x <= pcb_pkg::END_BITS'(1 << pcb_pkg::COORD_BITS);
			cfg_q.zend_y <= pcb_pkg::END_BITS'(1 << pcb_pkg::COORD_BITS);
		end else if (wr_en) begin
			case (pcb_pkg::reg_idx_t'(wr_index))
				pcb_pkg::REG_RED_COEFS:   cfg_q.gains[0] <= sat_set;
				pcb_pkg::REG_GREEN_COEFS: cfg_q.gains[1] <= sat_set;
				pcb_pkg::REG_BLUE_COEFS:  cfg_q.gains[2] <= sat_set;
				pcb_pkg::REG_ZONE_MIN_X:  cfg_q.zmin_x <= wr_data[pcb_pkg::COORD_BITS-1:0];
				pcb_pkg::REG_ZONE_MIN_Y:  cfg_q.zmin_y <= wr_data[pcb_pkg::COORD_BITS-1:0];
				pcb_pkg::REG_ZONE_END_X:  cfg_q.zend_x <= wr_data[pcb_pkg::END_BITS-1:0];
				pcb_pkg::REG_ZONE_END_Y:  cfg_q.zend_y <= wr_data[pcb_pkg::END_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/pcb_mask.sv
// pcb_mask: lightness and shadow/midtone/highlight masks, four pipeline stages
// shared by all channel lanes; uses pcb_pkg
module pcb_mask (
	input  logic                           clk,
	input  logic [pcb_pkg::CHANNEL_BITS-1:0] red,
	input  logic [pcb_pkg::CHANNEL_BITS-1:0] green,
	input  logic [pcb_pkg::CHANNEL_BITS-1:0] blue,
	output pcb_pkg::masks_t                masks
);

	logic [pcb_pkg::CHANNEL_BITS-1:0] mx, mn;
	logic [pcb_pkg::SUM_BITS-1:0]     sum_s1;
	logic [pcb_pkg::L4_PROD_BITS-1:0] l4_prod;
	logic [pcb_pkg::L4_BITS-1:0]      l4_s2;
	logic signed [pcb_pkg::DIFF_BITS-1:0] l4_ext;
	logic [pcb_pkg::MASK_BITS-1:0]    sh_s3, hi_s3, m1_s3, m2_s3;
	logic [2*pcb_pkg::MASK_BITS-1:0]  mid_prod;
	pcb_pkg::masks_t                  masks_s4;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
	end

	// reciprocal is exact for every max+min sum, no correction step needed
	assign l4_prod = pcb_pkg::L4_PROD_BITS'(sum_s1) *
		pcb_pkg::L4_PROD_BITS'(pcb_pkg::L4_RECIP);
	assign l4_ext  = $signed(pcb_pkg::DIFF_BITS'(l4_s2));
	assign mid_prod = (2*pcb_pkg::MASK_BITS)'(m1_s3) * (2*pcb_pkg::MASK_BITS)'(m2_s3);

	always_ff @(posedge clk) begin
		sum_s1 <= pcb_pkg::SUM_BITS'(mx) + pcb_pkg::SUM_BITS'(mn);
		l4_s2  <= l4_prod[pcb_pkg::L4_SH +: pcb_pkg::L4_BITS];
		sh_s3  <= pcb_pkg::clamp_mask($signed(pcb_pkg::DIFF_BITS'(pcb_pkg::K_SH)) - l4_ext);
		m1_s3  <= pcb_pkg::clamp_mask(l4_ext - $signed(pcb_pkg::DIFF_BITS'(pcb_pkg::K_M1)));
		m2_s3  <= pcb_pkg::clamp_mask($signed(pcb_pkg::DIFF_BITS'(pcb_pkg::K_M2)) - l4_ext);
		hi_s3  <= pcb_pkg::clamp_mask(l4_ext - $signed(pcb_pkg::DIFF_BITS'(pcb_pkg::K_HI)));
		masks_s4[0] <= sh_s3;
		masks_s4[1] <= mid_prod[16 +: pcb_pkg::MASK_BITS];
		masks_s4[2] <= hi_s3;
	end

	assign masks = masks_s4;

endmodule

>>> design/pcb_lane.sv
// pcb_lane: one channel of the balance, weighted gain sum, 0.7 scale and clamp
// four pipeline stages; uses pcb_pkg
module pcb_lane (
	input  logic                             clk,
	input  pcb_pkg::masks_t                  masks,
	input  pcb_pkg::gain_set_t               gains,
	input  logic [pcb_pkg::CHANNEL_BITS-1:0] chan,
	output logic [pcb_pkg::CHANNEL_BITS-1:0] balanced
);

	logic signed [pcb_pkg::MASK_BITS+pcb_pkg::GAIN_BITS:0] full [pcb_pkg::NUM_ZONES];
	logic signed [pcb_pkg::PROD_BITS-1:0] p_s5 [pcb_pkg::NUM_ZONES];
	logic signed [pcb_pkg::ACC_BITS-1:0]  acc_s6;
	logic signed [pcb_pkg::ACC_BITS+pcb_pkg::SCALE_BITS-1:0] scaled;
	logic signed [pcb_pkg::D_BITS-1:0]    d_s7;
	logic signed [pcb_pkg::EF_BITS-1:0]   ef;
	logic signed [pcb_pkg::E_BITS-1:0]    e;
	logic signed [pcb_pkg::V_BITS-1:0]    v;
	logic [pcb_pkg::CHANNEL_BITS-1:0]     c_s5, c_s6, c_s7, out_s8;
	logic [pcb_pkg::CHANNEL_BITS-1:0]     clamped;

	always_comb begin
		for (int z = 0; z < pcb_pkg::NUM_ZONES; z++) begin
			full[z] = $signed({1'b0, masks[z]}) * $signed(gains[z]);
		end
	end

	// weighted sum stays within +-3 * 2^30, so 33 bits hold it
	assign scaled = acc_s6 * $signed({1'b0, pcb_pkg::GAIN_BITS'(pcb_pkg::SCALE_Q16)});
	assign ef = d_s7 * $signed({1'b0, pcb_pkg::CHANNEL_BITS'(pcb_pkg::CMAX)});
	assign e  = $signed(ef[pcb_pkg::EF_BITS-1:30]);
	assign v  = $signed(pcb_pkg::V_BITS'(c_s7)) + pcb_pkg::V_BITS'(e);

	always_comb begin
		if (v < 0)
			clamped = '0;
		else if (v > $signed(pcb_pkg::V_BITS'(pcb_pkg::CMAX)))
			clamped = pcb_pkg::CHANNEL_BITS'(pcb_pkg::CMAX);
		else
			clamped = v[pcb_pkg::CHANNEL_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		for (int z = 0; z < pcb_pkg::NUM_ZONES; z++) begin
			p_s5[z] <= full[z][pcb_pkg::PROD_BITS-1:0];
		end
		c_s5   <= chan;
		acc_s6 <= pcb_pkg::ACC_BITS'(p_s5[0]) + pcb_pkg::ACC_BITS'(p_s5[1]) +
			pcb_pkg::ACC_BITS'(p_s5[2]);
		c_s6   <= c_s5;
		// arithmetic shift floors toward minus infinity
		d_s7   <= $signed(scaled[16 +: pcb_pkg::D_BITS]);
		c_s7   <= c_s6;
		out_s8 <= clamped;
	end

	assign balanced = out_s8;

endmodule

>>> design/pixel_color_balance_unit.sv
// pixel_color_balance_unit: shadows/midtones/highlights color balance per pixel
// throughput: one pixel per clock; busy is always low, since the pipeline never stalls
// results leave on a one-cycle done strobe; the receiver cannot stall
// arst_n clears the valid line and loads the register reset values
// uses pcb_pkg, pcb_cfg, pcb_mask and pcb_lane
module pixel_color_balance_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  pcb_pkg::pix_in_t              pixel,
	output logic                          done,
	output pcb_pkg::pix_out_t             result,
	input  logic                          wr_en,
	input  pcb_pkg::reg_addr_t            wr_index,
	input  logic [pcb_pkg::COEF_BITS-1:0] wr_data
);

	pcb_pkg::cfg_t     cfg;
	pcb_pkg::masks_t   masks;
	pcb_pkg::pix_in_t  pix_pipe_q [pcb_pkg::PIPE_DEPTH-1];
	logic              in_pipe_q  [pcb_pkg::PIPE_DEPTH-1];
	logic [pcb_pkg::PIPE_DEPTH-1:0] vld_q;
	logic [pcb_pkg::CHANNEL_BITS-1:0] bal [pcb_pkg::NUM_LANES];
	logic [pcb_pkg::CHANNEL_BITS-1:0] chan_s4 [pcb_pkg::NUM_LANES];
	logic              in_zone;
	pcb_pkg::pix_out_t result_q;

	pcb_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	assign in_zone = (pixel.pix_x >= cfg.zmin_x) && (pixel.pix_y >= cfg.zmin_y) &&
		(pcb_pkg::END_BITS'(pixel.pix_x) < cfg.zend_x) &&
		(pcb_pkg::END_BITS'(pixel.pix_y) < cfg.zend_y);

	pcb_mask u_mask (
		.clk   (clk),
		.red   (pixel.red_in),
		.green (pixel.green_in),
		.blue  (pixel.blue_in),
		.masks (masks)
	);

	// pixel at stage 4 lines up with the masks
	assign chan_s4[0] = pix_pipe_q[3].red_in;
	assign chan_s4[1] = pix_pipe_q[3].green_in;
	assign chan_s4[2] = pix_pipe_q[3].blue_in;

	for (genvar i = 0; i < pcb_pkg::NUM_LANES; i++) begin : g_lane
		pcb_lane u_lane (
			.clk      (clk),
			.masks    (masks),
			.gains    (cfg.gains[i]),
			.chan     (chan_s4[i]),
			.balanced (bal[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[pcb_pkg::PIPE_DEPTH-2:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		pix_pipe_q[0] <= pixel;
		in_pipe_q[0]  <= in_zone;
		for (int s = 1; s < pcb_pkg::PIPE_DEPTH-1; s++) begin
			pix_pipe_q[s] <= pix_pipe_q[s-1];
			in_pipe_q[s]  <= in_pipe_q[s-1];
		end
		// merge: lane results for pixels in the window, originals otherwise
		if (in_pipe_q[pcb_pkg::PIPE_DEPTH-2]) begin
			result_q.red_out   <= bal[0];
			result_q.green_out <= bal[1];
			result_q.blue_out  <= bal[2];
		end else begin
			result_q.red_out   <= pix_pipe_q[pcb_pkg::PIPE_DEPTH-2].red_in;
			result_q.green_out <= pix_pipe_q[pcb_pkg::PIPE_DEPTH-2].green_in;
			result_q.blue_out  <= pix_pipe_q[pcb_pkg::PIPE_DEPTH-2].blue_in;
		end
		result_q.was_adjusted <= in_pipe_q[pcb_pkg::PIPE_DEPTH-2];
	end

	assign busy   = 1'b0;
	assign done   = vld_q[pcb_pkg::PIPE_DEPTH-1];
	assign result = result_q;

endmodule

>>> test/tb_pixel_color_balance_unit.sv
// tb_pixel_color_balance_unit: self-checking bench for the pixel color balance unit
// predicts every balanced pixel in a small class and compares result beats in order
// depends on pcb_pkg and pixel_color_balance_unit
module tb_pixel_color_balance_unit;
	import pcb_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 2 * PIPE_DEPTH + 4;
	localparam int RANDOM_PHASES = 8;
	localparam int HALF_PHASE    = 106;
	localparam reg_addr_t NO_SUCH_REG = 3'd7;

	// lightness knees and the 0.7 factor, all Q16
	localparam longint Q16_ONE     = 65536;
	localparam longint SHADOW_KNEE = 120062;
	localparam longint MID_RISE    = 54526;
	localparam longint MID_FALL    = 207618;
	localparam longint HIGH_KNEE   = 142082;
	localparam longint BAL_SCALE   = 45875;
	localparam longint GAIN_LIMIT  = 16384;
	localparam longint CHAN_MAX    = (longint'(1) << CHANNEL_BITS) - 1;

	class color_balance_board;
		logic [COEF_BITS-1:0] gains [NUM_LANES];
		logic [COORD_BITS-1:0] zmin_x, zmin_y;
		logic [END_BITS-1:0] zend_x, zend_y;
		pix_out_t expected_q [$];
		int errors;
		int beats;

		function new();
			foreach (gains[i])
				gains[i] = '0;
			zmin_x = '0;
			zmin_y = '0;
			zend_x = END_BITS'(4096);
			zend_y = END_BITS'(4096);
			errors = 0;
			beats = 0;
		endfunction

		function void set_register(reg_addr_t idx, logic [COEF_BITS-1:0] data);
			case (idx)
				REG_RED_COEFS:   gains[0] = data;
				REG_GREEN_COEFS: gains[1] = data;
				REG_BLUE_COEFS:  gains[2] = data;
				REG_ZONE_MIN_X:  zmin_x = data[COORD_BITS-1:0];
				REG_ZONE_MIN_Y:  zmin_y = data[COORD_BITS-1:0];
				REG_ZONE_END_X:  zend_x = data[END_BITS-1:0];
				REG_ZONE_END_Y:  zend_y = data[END_BITS-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp_ramp(longint v);
			if (v < 0)
				return 0;
			if (v > Q16_ONE)
				return Q16_ONE;
			return v;
		endfunction

		function longint zone_gain(logic [COEF_BITS-1:0] pk, int zone);
			logic signed [GAIN_BITS-1:0] raw;
			longint g;
			raw = pk[zone*GAIN_BITS +: GAIN_BITS];
			g = longint'(raw);
			if (g > GAIN_LIMIT)
				g = GAIN_LIMIT;
			else if (g < -GAIN_LIMIT)
				g = -GAIN_LIMIT;
			return g;
		endfunction

		function logic [CHANNEL_BITS-1:0] lane_result(logic [CHANNEL_BITS-1:0] c,
				logic [COEF_BITS-1:0] pk, longint sh, longint mid, longint hi);
			longint acc, d, v, base;
			base = longint'(c);
			acc = sh * zone_gain(pk, 0) + mid * zone_gain(pk, 1) + hi * zone_gain(pk, 2);
			// weighted sum is Q30; arithmetic shifts floor toward minus infinity
			d = (acc * BAL_SCALE) >>> 16;
			v = base + ((d * CHAN_MAX) >>> 30);
			if (v < 0)
				v = 0;
			if (v > CHAN_MAX)
				v = CHAN_MAX;
			return v[CHANNEL_BITS-1:0];
		endfunction

		function void note_pixel(pix_in_t p);
			pix_out_t o;
			longint r, g, b, mx, mn, l4, sh, mid, hi;
			r = longint'(p.red_in);
			g = longint'(p.green_in);
			b = longint'(p.blue_in);
			if (!(p.pix_x >= zmin_x && p.pix_x < zend_x && p.pix_y >= zmin_y
					&& p.pix_y < zend_y)) begin
				o.red_out = p.red_in;
				o.green_out = p.green_in;
				o.blue_out = p.blue_in;
				o.was_adjusted = 1'b0;
				expected_q.push_back(o);
				return;
			end
			mx = r;
			mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			l4 = (2 * (mx + mn) * Q16_ONE) / CHAN_MAX;
			sh = clamp_ramp(SHADOW_KNEE - l4);
			mid = (clamp_ramp(l4 - MID_RISE) * clamp_ramp(MID_FALL - l4)) >>> 16;
			hi = clamp_ramp(l4 - HIGH_KNEE);
			o.red_out = lane_result(p.red_in, gains[0], sh, mid, hi);
			o.green_out = lane_result(p.green_in, gains[1], sh, mid, hi);
			o.blue_out = lane_result(p.blue_in, gains[2], sh, mid, hi);
			o.was_adjusted = 1'b1;
			expected_q.push_back(o);
		endfunction

		task report(string what);
			if (errors < 40)
				$display("mismatch at beat %0d: %s", beats, what);
			errors++;
		endtask

		task check_pixel(pix_out_t got);
			pix_out_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result beat %h with no pixel outstanding", got));
				return;
			end
			want = expected_q.pop_front();
			if (got.red_out !== want.red_out)
				report($sformatf("red_out %0d, expected %0d", got.red_out, want.red_out));
			if (got.green_out !== want.green_out)
				report($sformatf("green_out %0d, expected %0d", got.green_out, want.green_out));
			if (got.blue_out !== want.blue_out)
				report($sformatf("blue_out %0d, expected %0d", got.blue_out, want.blue_out));
			if (got.was_adjusted !== want.was_adjusted)
				report($sformatf("was_adjusted %b, expected %b", got.was_adjusted,
					want.was_adjusted));
			beats++;
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	pix_in_t pixel;
	logic done;
	pix_out_t result;
	logic wr_en;
	reg_addr_t wr_index;
	logic [COEF_BITS-1:0] wr_data;

	color_balance_board board;
	logic [COEF_BITS-1:0] cfg_now [8];
	int cycle_count = 0;

	pixel_color_balance_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel(pixel),
		.done(done),
		.result(result),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (wr_en)
				board.set_register(wr_index, wr_data);
			if (start && !busy)
				board.note_pixel(pixel);
			if (done)
				board.check_pixel(result);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_pixel_color_balance_unit: errors");
			$finish;
		end
	end

	task drive_pixel(pix_in_t p);
		@(negedge clk);
		start <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (busy);
	endtask

	task idle_for(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task write_reg(reg_addr_t idx, logic [COEF_BITS-1:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		cfg_now[idx] = data;
	endtask

	task end_writes();
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	function automatic pix_in_t make_pixel(int x, int y, int r, int g, int b);
		pix_in_t p;
		p.pix_x = COORD_BITS'(x);
		p.pix_y = COORD_BITS'(y);
		p.red_in = CHANNEL_BITS'(r);
		p.green_in = CHANNEL_BITS'(g);
		p.blue_in = CHANNEL_BITS'(b);
		return p;
	endfunction

	function automatic logic [GAIN_BITS-1:0] random_gain();
		int tmp;
		case ($urandom_range(0, 5))
			0: return 16'h4000;
			1: return 16'hC000;
			2: return GAIN_BITS'($urandom);
			default: begin
				tmp = $urandom_range(0, 32768);
				return GAIN_BITS'(tmp - 16384);
			end
		endcase
	endfunction

	// upper data bits beyond the register are don't-care, so fill them half the time
	function automatic logic [COEF_BITS-1:0] with_junk(logic [COEF_BITS-1:0] v, int bits);
		logic [COEF_BITS-1:0] junk;
		if ($urandom_range(0, 1) == 0)
			return v;
		junk = COEF_BITS'({$urandom, $urandom});
		return (junk << bits) | v;
	endfunction

	// bias coordinates toward the window edges
	function automatic logic [COORD_BITS-1:0] random_coord(logic [END_BITS-1:0] lo,
			logic [END_BITS-1:0] hi);
		case ($urandom_range(0, 7))
			0: return COORD_BITS'(lo - 13'd1);
			1: return lo[COORD_BITS-1:0];
			2: return COORD_BITS'(hi - 13'd1);
			3: return hi[COORD_BITS-1:0];
			default: return COORD_BITS'($urandom);
		endcase
	endfunction

	function automatic pix_in_t random_pixel();
		pix_in_t p;
		logic [CHANNEL_BITS-1:0] shade;
		p.pix_x = random_coord({1'b0, cfg_now[REG_ZONE_MIN_X][COORD_BITS-1:0]},
			cfg_now[REG_ZONE_END_X][END_BITS-1:0]);
		p.pix_y = random_coord({1'b0, cfg_now[REG_ZONE_MIN_Y][COORD_BITS-1:0]},
			cfg_now[REG_ZONE_END_Y][END_BITS-1:0]);
		if ($urandom_range(0, 3) == 0) begin
			shade = CHANNEL_BITS'($urandom);
			p.red_in = shade;
			p.green_in = shade;
			p.blue_in = shade;
		end else begin
			p.red_in = CHANNEL_BITS'($urandom);
			p.green_in = CHANNEL_BITS'($urandom);
			p.blue_in = CHANNEL_BITS'($urandom);
		end
		return p;
	endfunction

	task random_config();
		logic [END_BITS-1:0] mnx, mny, enx, eny;
		int pick;
		write_reg(REG_RED_COEFS, {random_gain(), random_gain(), random_gain()});
		write_reg(REG_GREEN_COEFS, {random_gain(), random_gain(), random_gain()});
		write_reg(REG_BLUE_COEFS, {random_gain(), random_gain(), random_gain()});
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			mnx = '0;
			mny = '0;
			enx = END_BITS'(4096);
			eny = END_BITS'(4096);
		end else if (pick < 8) begin
			mnx = END_BITS'($urandom_range(0, 3000));
			mny = END_BITS'($urandom_range(0, 3000));
			enx = END_BITS'($urandom_range(mnx, 4096));
			eny = END_BITS'($urandom_range(mny, 4096));
		end else if (pick == 8) begin
			mnx = END_BITS'($urandom_range(0, 4095));
			mny = END_BITS'($urandom_range(0, 4095));
			enx = END_BITS'($urandom_range(0, 8191));
			eny = END_BITS'($urandom_range(0, 8191));
		end else begin
			// row bound of zero turns processing off
			mnx = END_BITS'($urandom_range(0, 4095));
			mny = '0;
			enx = END_BITS'($urandom_range(0, 4096));
			eny = '0;
		end
		write_reg(REG_ZONE_MIN_X, with_junk(COEF_BITS'(mnx), COORD_BITS));
		write_reg(REG_ZONE_MIN_Y, with_junk(COEF_BITS'(mny), COORD_BITS));
		write_reg(REG_ZONE_END_X, with_junk(COEF_BITS'(enx), END_BITS));
		write_reg(REG_ZONE_END_Y, with_junk(COEF_BITS'(eny), END_BITS));
		if ($urandom_range(0, 3) == 0)
			write_reg(NO_SUCH_REG, COEF_BITS'({$urandom, $urandom}));
		end_writes();
	endtask

	task send_stream(int count);
		int left, burst;
		left = count;
		while (left > 0) begin
			burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			if (burst > left)
				burst = left;
			repeat (burst)
				drive_pixel(random_pixel());
			left -= burst;
			idle_for($urandom_range(1, 11));
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		pixel = '0;
		wr_en = 1'b0;
		wr_index = REG_RED_COEFS;
		wr_data = '0;
		foreach (cfg_now[i])
			cfg_now[i] = '0;
		cfg_now[REG_ZONE_END_X] = COEF_BITS'(4096);
		cfg_now[REG_ZONE_END_Y] = COEF_BITS'(4096);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values: zero gains over the full frame
		drive_pixel(make_pixel(0, 0, 0, 0, 0));
		drive_pixel(make_pixel(4095, 4095, 255, 255, 255));
		wait_drained();

		// full and oversized gains of both signs, window with three real edges and its bottom at the frame end
		write_reg(REG_RED_COEFS, {16'h8000, 16'h7FFF, 16'h4000});
		write_reg(REG_GREEN_COEFS, {16'hC000, 16'hC000, 16'hC000});
		write_reg(REG_BLUE_COEFS, {16'h1234, 16'hE000, 16'h2000});
		write_reg(REG_ZONE_MIN_X, 48'd100);
		write_reg(REG_ZONE_MIN_Y, 48'd200);
		write_reg(REG_ZONE_END_X, 48'd4000);
		write_reg(REG_ZONE_END_Y, 48'd4096);
		write_reg(NO_SUCH_REG, 48'hFFFF_FFFF_FFFF);
		end_writes();
		drive_pixel(make_pixel(100, 200, 0, 0, 0));
		drive_pixel(make_pixel(3999, 4095, 255, 255, 255));
		drive_pixel(make_pixel(99, 200, 10, 20, 30));
		drive_pixel(make_pixel(4000, 300, 40, 50, 60));
		drive_pixel(make_pixel(500, 199, 70, 80, 90));
		// grays straddling each mask knee
		drive_pixel(make_pixel(2000, 2000, 53, 53, 53));
		drive_pixel(make_pixel(2000, 2000, 54, 54, 54));
		drive_pixel(make_pixel(2000, 2000, 116, 116, 116));
		drive_pixel(make_pixel(2000, 2000, 117, 117, 117));
		drive_pixel(make_pixel(2000, 2000, 138, 138, 138));
		drive_pixel(make_pixel(2000, 2000, 139, 139, 139));
		drive_pixel(make_pixel(2000, 2000, 201, 201, 201));
		drive_pixel(make_pixel(2000, 2000, 202, 202, 202));
		drive_pixel(make_pixel(1000, 1000, 255, 0, 0));
		drive_pixel(make_pixel(1000, 1000, 0, 255, 0));
		drive_pixel(make_pixel(1000, 1000, 0, 0, 255));
		drive_pixel(make_pixel(1000, 1000, 255, 0, 255));
		wait_drained();

		write_reg(REG_ZONE_END_Y, 48'd0);
		end_writes();
		drive_pixel(make_pixel(1000, 1000, 128, 128, 128));
		wait_drained();

		// one-pixel window in the far corner
		write_reg(REG_ZONE_MIN_X, 48'd4095);
		write_reg(REG_ZONE_MIN_Y, 48'd4095);
		write_reg(REG_ZONE_END_X, 48'd4096);
		write_reg(REG_ZONE_END_Y, 48'd4096);
		end_writes();
		drive_pixel(make_pixel(4095, 4095, 200, 100, 50));
		drive_pixel(make_pixel(0, 0, 200, 100, 50));
		wait_drained();

		write_reg(REG_ZONE_MIN_X, 48'd500);
		write_reg(REG_ZONE_END_X, 48'd500);
		write_reg(REG_ZONE_MIN_Y, 48'd0);
		end_writes();
		drive_pixel(make_pixel(500, 500, 30, 160, 250));

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_drained();
			random_config();
			send_stream(HALF_PHASE);
			wait_drained();
			send_stream(HALF_PHASE);
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("tb_pixel_color_balance_unit: clean");
		else
			$display("tb_pixel_color_balance_unit: errors");
		$finish;
	end

endmodule

>>> filelist.f
design/pcb_pkg.sv
design/pcb_cfg.sv
design/pcb_mask.sv
design/pcb_lane.sv
design/pixel_color_balance_unit.sv
test/tb_pixel_color_balance_unit.sv
